FILE: rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 message hasher.
// No dependencies; imported by every module of the block.
`default_nettype none

package sha1_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [3:0] LEN_BYTES = 4'd8;
    localparam logic [2:0] LAST_WORD_NUM = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/sha1_front.sv
// Front end: accepts input transactions, drops idle items, queues the rest.
// Depends on sha1_pkg.
`default_nettype none

module sha1_front #(
    parameter int QueueDepth = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  sha1_pkg::t_in_item  i_in_item,
    output sha1_pkg::t_cmd      o_cmd,
    input  wire                 i_take
);
    import sha1_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_in_item          r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_in_stall = (r_cnt == CntW'(QueueDepth));
    assign push = i_in_valid && !o_in_stall &&
                  (i_in_item.has_byte || i_in_item.end_of_message);
    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.item = r_mem[r_rd];
    assign pop = o_cmd.valid && i_take;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(QueueDepth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(QueueDepth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sha1_back.sv
// Back end: block gathering, padding, 80-round compression and digest output.
// Depends on sha1_pkg; fed by sha1_front.
`default_nettype none

module sha1_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sha1_pkg::t_cmd       i_cmd,
    output logic                 o_take,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sha1_pkg::t_out_item  o_out_item
);
    import sha1_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state       r_state;
    t_state       n_state;
    logic [31:0]  r_h [5];
    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [63:0]  r_count;
    logic [63:0]  n_count;
    logic [63:0]  r_len;
    logic [5:0]   r_pos;
    logic [6:0]   r_rnd;
    logic [2:0]   r_wnum;
    logic [3:0]   r_len_left;
    logic         r_first;
    logic         r_pad_busy;
    logic         r_out_valid;
    t_out_item    r_out_item;

    logic         in_byte;
    logic         pad_zero;
    logic         push_en;
    logic [7:0]   push_byte;
    logic         out_load;
    logic [31:0]  f;
    logic [31:0]  k;
    logic [31:0]  w_next;
    logic [31:0]  a_new;

    assign o_take      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign in_byte  = (r_state == S_IDLE) && i_cmd.valid && i_cmd.item.has_byte;
    assign pad_zero = (r_len_left == LEN_BYTES) && (r_pos != LEN_POS);
    assign push_en  = in_byte || (r_state == S_PAD);
    assign n_count  = r_count + {63'd0, i_cmd.item.has_byte};
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_state == S_IDLE) begin
            push_byte = i_cmd.item.data_byte;
        end else if (r_first) begin
            push_byte = PAD_BYTE;
        end else if (pad_zero) begin
            push_byte = 8'h00;
        end else begin
            push_byte = r_len[63:56];
        end
    end

    always_comb begin
        if (r_rnd inside {[7'd0:7'd19]}) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K_R0;
        end else if (r_rnd inside {[7'd20:7'd39]}) begin
            f = r_b ^ r_c ^ r_d;
            k = K_R1;
        end else if (r_rnd inside {[7'd40:7'd59]}) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K_R2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K_R3;
        end
    end

    assign w_next = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                     r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign a_new  = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.item.has_byte && r_pos == LAST_POS) begin
                        n_state = S_ROUND;
                    end else if (i_cmd.item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == LAST_POS) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!r_pad_busy) begin
                    n_state = S_IDLE;
                end else if (r_len_left == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_load && r_wnum == LAST_WORD_NUM) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Block window: byte shift while gathering, word shift while compressing
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], push_byte};
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en && r_pos == LAST_POS) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == S_ROUND) begin
            r_a <= a_new;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (r_state == S_IDLE && i_cmd.valid && i_cmd.item.end_of_message) begin
            r_len <= {n_count[60:0], 3'b000};
        end else if (r_state == S_PAD && !r_first && !pad_zero) begin
            r_len <= {r_len[55:0], 8'h00};
        end
        if (out_load) begin
            r_out_item.digest_word <= r_h[r_wnum];
            r_out_item.word_number <= r_wnum;
            r_out_item.last_word   <= (r_wnum == LAST_WORD_NUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= H_INIT;
            r_count     <= '0;
            r_pos       <= '0;
            r_rnd       <= '0;
            r_wnum      <= '0;
            r_len_left  <= '0;
            r_first     <= 1'b0;
            r_pad_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (push_en) begin
                r_pos <= r_pos + 6'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_count <= n_count;
                        if (i_cmd.item.end_of_message) begin
                            r_pad_busy <= 1'b1;
                            r_first    <= 1'b1;
                            r_len_left <= LEN_BYTES;
                        end
                    end
                end
                S_PAD: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else if (!pad_zero) begin
                        r_len_left <= r_len_left - 4'd1;
                    end
                end
                S_ROUND: begin
                    r_rnd <= (r_rnd == LAST_ROUND) ? '0 : r_rnd + 7'd1;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        if (r_wnum == LAST_WORD_NUM) begin
                            r_wnum     <= '0;
                            r_h        <= H_INIT;
                            r_count    <= '0;
                            r_pad_busy <= 1'b0;
                        end else begin
                            r_wnum <= r_wnum + 3'd1;
                        end
                    end
                end
                default: begin
                    r_rnd <= '0;
                end
            endcase
        end
    end

    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_rnd == '0))
        else $error("round counter running outside compression");

    a_pad_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD || r_state == S_OUT) |-> r_pad_busy)
        else $error("padding or output without a pending message end");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.last_word == (r_out_item.word_number == LAST_WORD_NUM)))
        else $error("last word flag does not match word number");

    a_round_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && $past(r_state) != S_ROUND) |-> (r_pos == '0))
        else $error("compression started on a partial block");

endmodule

`default_nettype wire

FILE: rtl/sha1_message_hasher_core.sv
// Channel    | direction | handshake                  | payload
// input      | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
// output     | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
// Each message byte is shifted into the block window in the back end; every full
// 64-byte block then runs 80 rounds on one round unit, then the chaining add.
// A message end adds the padding bytes up to the block end, one or two
// compressions, and five digest transactions.
// Reset is synchronous and active low; it restores the initial chaining values.
// The input queue takes items, until it is full, while the back end compresses or the output stalls.
// Depends on sha1_pkg, sha1_front and sha1_back.
`default_nettype none

module sha1_message_hasher_core #(
    parameter int QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  sha1_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sha1_pkg::t_out_item  o_out_item
);
    import sha1_pkg::*;

    t_cmd  cmd;
    logic  take;

    sha1_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd      (cmd),
        .i_take     (take)
    );

    sha1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: test/sha1_message_hasher_core_tb.sv
// Regression bench for sha1_message_hasher_core: directed byte messages, then random ones.
// Digests come from a built-in SHA-1 hasher, or from known digests on some directed rows, and are checked word by word.
// Depends on sha1_pkg and the rtl of sha1_message_hasher_core.
`timescale 1ns / 100ps

module sha1_message_hasher_core_tb;
    import sha1_pkg::*;

    localparam int DIRECTED_ROWS = 16;
    localparam int RANDOM_ITEMS = 355;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PRINT_LIMIT = 200;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    typedef struct packed {
        t_in_item     item;
        logic         typed;
        logic [159:0] digest;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic [31:0] sha_chain [5];
    logic [31:0] sha_block [16];
    logic [63:0] msg_byte_count;
    t_out_item   digest_fifo [$];

    int errors = 0;
    int messages_done = 0;
    int byte_items = 0;
    int words_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_asks = 0;
    int holdoff_served = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    sha1_message_hasher_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_in_item mk_item(logic [7:0] b, logic hb, logic eom);
        t_in_item it;
        it.data_byte = b;
        it.has_byte = hb;
        it.end_of_message = eom;
        return it;
    endfunction

    function automatic t_dir_row directed_row(int n);
        t_dir_row r;
        r = '{item: '0, typed: 1'b0, digest: '0};
        case (n)
            0:  r = '{mk_item(8'h00, 1'b0, 1'b1), 1'b1, EMPTY_DIGEST};
            1:  r.item = mk_item(8'h61, 1'b1, 1'b0);
            2:  r.item = mk_item(8'hFF, 1'b0, 1'b0);
            3:  r.item = mk_item(8'h62, 1'b1, 1'b0);
            4:  r = '{mk_item(8'h63, 1'b1, 1'b1), 1'b1, ABC_DIGEST};
            5:  r = '{mk_item(8'hA5, 1'b0, 1'b1), 1'b1, EMPTY_DIGEST};
            6:  r.item = mk_item(8'h00, 1'b1, 1'b0);
            7:  r.item = mk_item(8'hFF, 1'b1, 1'b0);
            8:  r.item = mk_item(8'h80, 1'b1, 1'b0);
            9:  r.item = mk_item(8'h7F, 1'b1, 1'b1);
            10: r.item = mk_item(8'hFF, 1'b1, 1'b1);
            11: r.item = mk_item(8'h01, 1'b1, 1'b0);
            12: r.item = mk_item(8'hFE, 1'b0, 1'b1);
            13: r.item = mk_item(8'h00, 1'b0, 1'b0);
            14: r.item = mk_item(8'hC3, 1'b1, 1'b1);
            default: r = '{mk_item(8'h00, 1'b0, 1'b1), 1'b1, EMPTY_DIGEST};
        endcase
        return r;
    endfunction

    function automatic void load_msg_byte(int pos, logic [7:0] b);
        sha_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endfunction

    function automatic void compress_sha_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, mix, sum;
        w = sha_block;
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                mix = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
                wt = {mix[30:0], mix[31]};
                w[t % 16] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 5; i++) sha_chain[i] = H_INIT[i];
        sha_block = '{default: '0};
        msg_byte_count = '0;
    endfunction

    // Advance the hasher by one transaction; push the digest words on a message end.
    function automatic void absorb_item(t_in_item it, logic typed, logic [159:0] digest);
        int pos;
        logic [63:0] bit_len;
        t_out_item word;
        if (it.has_byte) begin
            pos = int'(msg_byte_count[5:0]);
            load_msg_byte(pos, it.data_byte);
            msg_byte_count++;
            if (pos == 63) compress_sha_block();
        end
        if (!it.end_of_message) return;
        pos = int'(msg_byte_count[5:0]);
        bit_len = msg_byte_count << 3;
        load_msg_byte(pos, PAD_BYTE);
        for (int p = pos + 1; p < 64; p++) load_msg_byte(p, 8'h00);
        if (pos >= 56) begin
            compress_sha_block();
            sha_block = '{default: '0};
        end
        sha_block[14] = bit_len[63:32];
        sha_block[15] = bit_len[31:0];
        compress_sha_block();
        for (int i = 0; i < 5; i++) begin
            word.digest_word = typed ? digest[159 - 32 * i -: 32] : sha_chain[i];
            word.word_number = 3'(i);
            word.last_word = (3'(i) == LAST_WORD_NUM);
            digest_fifo.push_back(word);
        end
        for (int i = 0; i < 5; i++) sha_chain[i] = H_INIT[i];
        msg_byte_count = '0;
        messages_done++;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s got %h want %h (message %0d)", $time, what, got, want,
                     messages_done);
        errors++;
    endtask

    task automatic send_item(t_in_item it, logic typed = 1'b0, logic [159:0] digest = '0);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.has_byte || it.end_of_message) byte_items++;
        absorb_item(it, typed, digest);
    endtask

    task automatic send_message(int len, logic bare_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99, 0) < 5)
                send_item(mk_item(8'($urandom), 1'b0, 1'b0));
            send_item(mk_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end));
        end
        if (bare_end || len == 0)
            send_item(mk_item(8'($urandom), 1'b0, 1'b1));
    endtask

    task automatic check_digest_word(t_out_item got);
        t_out_item want;
        if (digest_fifo.size() == 0) begin
            report_mismatch("unexpected digest_word", got.digest_word, '0);
            return;
        end
        want = digest_fifo.pop_front();
        words_checked++;
        if (got.digest_word !== want.digest_word)
            report_mismatch("digest_word", got.digest_word, want.digest_word);
        if (got.word_number !== want.word_number)
            report_mismatch("word_number", 32'(got.word_number), 32'(want.word_number));
        if (got.last_word !== want.last_word)
            report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) check_digest_word(o_out_item);
        if (holdoff_left != 0) begin
            holdoff_left--;
            out_stall <= 1'b1;
        end else if (holdoff_asks != holdoff_served) begin
            holdoff_served = holdoff_asks;
            holdoff_left = HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("sha1_message_hasher_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_dir_row row;
        int len;
        int pick;
        int left;
        restart_hash();
        send_idle_pct = 30;
        recv_stall_pct <= 49;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = directed_row(n);
            send_item(row.item, row.typed, row.digest);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
            recv_stall_pct <= (phase == 0) ? 49 : (phase == 1) ? 30 : 0;
            holdoff_asks <= holdoff_asks + 1;
            while (byte_items < DIRECTED_ROWS + (phase + 1) * RANDOM_ITEMS / 3) begin
                pick = $urandom_range(99, 0);
                if (pick < 70) len = $urandom_range(8, 0);
                else if (pick < 92) len = $urandom_range(66, 54);
                else len = $urandom_range(130, 118);
                left = DIRECTED_ROWS + (phase + 1) * RANDOM_ITEMS / 3 - byte_items;
                if (len > left) len = left;
                send_message(len, $urandom_range(3, 0) == 0);
            end
        end
        in_valid <= 1'b0;

        while (digest_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d messages in %0d byte transactions, %0d digest words checked",
                 messages_done, byte_items, words_checked);
        $display("three stall mixes with long output hold-offs, %0d mismatches", errors);
        if (errors == 0) begin
            $display("sha1_message_hasher_core regression: pass");
        end else begin
            $display("sha1_message_hasher_core regression: fail");
        end
        $finish;
    end

endmodule
